// ===== rtl/mppt_pkg.sv =====
// Shared types, screen constants and decode helpers for the mouse position tracker.
package mppt_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;

    localparam int BYTE_W  = 8;
    localparam int MOVE_W  = 9;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int SCR_W   = 5;
    localparam int BTN_W   = 3;
    localparam int SUM_W   = MOVE_W + 1;

    localparam logic [COL_W-1:0] COL_MAX   = COL_W'(SCREEN_COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_MAX   = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [COL_W-1:0] COL_RESET = COL_W'(40);
    localparam logic [ROW_W-1:0] ROW_RESET = ROW_W'(12);
    localparam logic [3:0]       MAG_CAP   = 4'd15;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // One decoded packet, before acceleration and cursor update.
    typedef struct packed {
        logic        [BTN_W-1:0]  buttons;
        logic signed [MOVE_W-1:0] dx;
        logic signed [MOVE_W-1:0] dy;
        logic signed [SCR_W-1:0]  scroll;
    } t_pkt;

    function automatic logic [3:0] boost_lut(input logic [3:0] idx);
        logic [3:0] v;
        begin
            case (idx)
                4'd0, 4'd1, 4'd2:   v = 4'd0;
                4'd3, 4'd4, 4'd5:   v = 4'd1;
                4'd6, 4'd7:         v = 4'd2;
                4'd8:               v = 4'd3;
                4'd9:               v = 4'd4;
                4'd10:              v = 4'd5;
                4'd11:              v = 4'd6;
                4'd12:              v = 4'd8;
                4'd13:              v = 4'd10;
                4'd14:              v = 4'd12;
                default:            v = 4'd15;
            endcase
            return v;
        end
    endfunction

    // Magnitude-indexed acceleration; the boost carries the sign of the move.
    function automatic logic signed [MOVE_W-1:0] boost(input logic signed [MOVE_W-1:0] d);
        logic [MOVE_W-1:0]        mag;
        logic [3:0]               idx;
        logic signed [MOVE_W-1:0] b;
        begin
            mag = d[MOVE_W-1] ? MOVE_W'(-d) : MOVE_W'(d);
            idx = (mag > MOVE_W'(MAG_CAP)) ? MAG_CAP : mag[3:0];
            b   = $signed({{(MOVE_W-4){1'b0}}, boost_lut(idx)});
            return d[MOVE_W-1] ? MOVE_W'(d - b) : MOVE_W'(d + b);
        end
    endfunction

endpackage

// ===== rtl/mppt_front.sv =====
// Byte collector: gathers packet bytes and pushes one decoded packet record per packet.
module mppt_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_wheel_mode,
    input  logic               i_data_valid,
    output logic               o_data_ready,
    input  logic [7:0]         i_data_byte,
    output logic               o_push,
    output mppt_pkg::t_pkt     o_pkt,
    input  logic               i_fifo_ready
);
    import mppt_pkg::*;

    logic              r_wheel_mode;
    logic [1:0]        r_byte_count;
    logic [1:0]        n_byte_count;
    logic [BYTE_W-1:0] r_bytes [3];
    logic              w_complete;
    logic              w_accept;
    logic [BYTE_W-1:0] w_ybyte;
    logic [3:0]        w_nib;

    // Final index is 2 in three-byte mode, 3 in wheel mode.
    assign w_complete   = r_byte_count >= {1'b1, r_wheel_mode};
    assign o_data_ready = !w_complete || i_fifo_ready;
    assign w_accept     = i_data_valid && o_data_ready;
    assign o_push       = w_accept && w_complete;

    assign w_ybyte = r_wheel_mode ? r_bytes[2] : i_data_byte;
    assign w_nib   = i_data_byte[3:0];

    always_comb begin
        o_pkt.buttons = r_bytes[0][BTN_W-1:0];
        o_pkt.dx      = $signed({r_bytes[1][BYTE_W-1], r_bytes[1]});
        o_pkt.dy      = MOVE_W'(-$signed({w_ybyte[BYTE_W-1], w_ybyte}));
        o_pkt.scroll  = r_wheel_mode ? SCR_W'(-$signed({w_nib[3], w_nib})) : '0;
    end

    always_comb begin
        n_byte_count = r_byte_count;
        if (w_accept) begin
            n_byte_count = w_complete ? 2'd0 : 2'(r_byte_count + 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_mode <= 1'b0;
            r_byte_count <= 2'd0;
        end else begin
            r_byte_count <= n_byte_count;
            if (i_cfg_valid) begin
                r_wheel_mode <= i_cfg_wheel_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_complete) begin
            r_bytes[r_byte_count] <= i_data_byte;
        end
    end

    a_count_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> r_byte_count == 2'd0)
        else $error("byte count did not restart after a packet");

endmodule

// ===== rtl/mppt_fifo.sv =====
// Short queue of decoded packet records between the collector and the cursor stage.
module mppt_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mppt_pkg::t_pkt i_pkt,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output mppt_pkg::t_pkt o_pkt
);
    import mppt_pkg::*;

    t_pkt               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;
    logic               w_push;
    logic               w_pop;

    assign o_ready = r_count != FIFO_CW'(FIFO_DEPTH);
    assign o_valid = r_count != '0;
    assign o_pkt   = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= FIFO_AW'(r_wr_ptr + 1'b1);
            end
            if (w_pop) begin
                r_rd_ptr <= FIFO_AW'(r_rd_ptr + 1'b1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= FIFO_CW'(r_count + 1'b1);
                2'b01:   r_count <= FIFO_CW'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_pkt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_push_not_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("packet pushed into full queue");

endmodule

// ===== rtl/mppt_back.sv =====
// Cursor stage: applies acceleration, updates the saturating cursor, holds the result.
module mppt_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  mppt_pkg::t_pkt                      i_pkt,
    output logic                                o_pop,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic [mppt_pkg::BTN_W-1:0]          o_buttons,
    output logic signed [mppt_pkg::MOVE_W-1:0]  o_move_x,
    output logic signed [mppt_pkg::MOVE_W-1:0]  o_move_y,
    output logic [mppt_pkg::COL_W-1:0]          o_pos_x,
    output logic [mppt_pkg::ROW_W-1:0]          o_pos_y,
    output logic signed [mppt_pkg::SCR_W-1:0]   o_scroll
);
    import mppt_pkg::*;

    logic                     r_valid;
    logic [COL_W-1:0]         r_col;
    logic [ROW_W-1:0]         r_row;
    logic [COL_W-1:0]         n_col;
    logic [ROW_W-1:0]         n_row;
    logic signed [MOVE_W-1:0] w_bx;
    logic signed [MOVE_W-1:0] w_by;
    logic signed [SUM_W-1:0]  w_sum_x;
    logic signed [SUM_W-1:0]  w_sum_y;
    logic [BTN_W-1:0]         r_buttons;
    logic signed [MOVE_W-1:0] r_move_x;
    logic signed [MOVE_W-1:0] r_move_y;
    logic signed [SCR_W-1:0]  r_scroll;

    assign o_pop = i_valid && (!r_valid || i_res_ready);

    assign w_bx    = boost(i_pkt.dx);
    assign w_by    = boost(i_pkt.dy);
    assign w_sum_x = $signed({{(SUM_W-COL_W){1'b0}}, r_col}) + SUM_W'(w_bx);
    assign w_sum_y = $signed({{(SUM_W-ROW_W){1'b0}}, r_row}) + SUM_W'(w_by);

    always_comb begin
        if (w_sum_x < 0) begin
            n_col = '0;
        end else if (w_sum_x > $signed({{(SUM_W-COL_W){1'b0}}, COL_MAX})) begin
            n_col = COL_MAX;
        end else begin
            n_col = w_sum_x[COL_W-1:0];
        end
        if (w_sum_y < 0) begin
            n_row = '0;
        end else if (w_sum_y > $signed({{(SUM_W-ROW_W){1'b0}}, ROW_MAX})) begin
            n_row = ROW_MAX;
        end else begin
            n_row = w_sum_y[ROW_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_col   <= COL_RESET;
            r_row   <= ROW_RESET;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_col   <= n_col;
                r_row   <= n_row;
            end else if (i_res_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_buttons <= i_pkt.buttons;
            r_move_x  <= w_bx;
            r_move_y  <= w_by;
            r_scroll  <= i_pkt.scroll;
        end
    end

    assign o_res_valid = r_valid;
    assign o_buttons   = r_buttons;
    assign o_move_x    = r_move_x;
    assign o_move_y    = r_move_y;
    assign o_pos_x     = r_col;
    assign o_pos_y     = r_row;
    assign o_scroll    = r_scroll;

    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_col <= COL_MAX) && (r_row <= ROW_MAX))
        else $error("cursor left the screen after an update");

    a_cursor_only_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pop |=> $stable(r_col) && $stable(r_row))
        else $error("cursor moved without a packet");

endmodule

// ===== rtl/mouse_packet_position_tracker_unit.sv =====
// Top level of the mouse packet decoder with saturating cursor tracking.
// A packet's result passes from the collector through the packet queue into the cursor stage's output register.
// Throughput: one byte per cycle unless a packet's last byte waits on a full packet queue; one result per packet.
// A two-entry packet queue lets byte intake continue while a result waits on the output.
// Reset (synchronous, active low): byte count 0, three-byte mode, cursor at column 40, row 12.
module mouse_packet_position_tracker_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_wheel_mode,
    input  logic                                i_data_valid,
    output logic                                o_data_ready,
    input  logic [7:0]                          i_data_byte,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic [mppt_pkg::BTN_W-1:0]          o_buttons,
    output logic signed [mppt_pkg::MOVE_W-1:0]  o_move_x,
    output logic signed [mppt_pkg::MOVE_W-1:0]  o_move_y,
    output logic [mppt_pkg::COL_W-1:0]          o_pos_x,
    output logic [mppt_pkg::ROW_W-1:0]          o_pos_y,
    output logic signed [mppt_pkg::SCR_W-1:0]   o_scroll
);
    import mppt_pkg::*;

    logic w_push;
    logic w_fifo_ready;
    logic w_fifo_valid;
    logic w_pop;
    t_pkt w_front_pkt;
    t_pkt w_back_pkt;

    assign o_cfg_ready = 1'b1;

    mppt_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_wheel_mode (i_cfg_wheel_mode),
        .i_data_valid     (i_data_valid),
        .o_data_ready     (o_data_ready),
        .i_data_byte      (i_data_byte),
        .o_push           (w_push),
        .o_pkt            (w_front_pkt),
        .i_fifo_ready     (w_fifo_ready)
    );

    mppt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pkt   (w_front_pkt),
        .o_ready (w_fifo_ready),
        .i_pop   (w_pop),
        .o_valid (w_fifo_valid),
        .o_pkt   (w_back_pkt)
    );

    mppt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_fifo_valid),
        .i_pkt       (w_back_pkt),
        .o_pop       (w_pop),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_buttons   (o_buttons),
        .o_move_x    (o_move_x),
        .o_move_y    (o_move_y),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_scroll    (o_scroll)
    );

endmodule

// ===== verif/tb_mouse_packet_position_tracker_unit.sv =====
// Self-checking bench for the mouse packet decoder: directed table plus random byte streams.
`timescale 1ns / 1ps

module tb_mouse_packet_position_tracker_unit;
    import mppt_pkg::*;

    typedef struct packed {
        logic        [BTN_W-1:0]  buttons;
        logic signed [MOVE_W-1:0] move_x;
        logic signed [MOVE_W-1:0] move_y;
        logic        [COL_W-1:0]  pos_x;
        logic        [ROW_W-1:0]  pos_y;
        logic signed [SCR_W-1:0]  scroll;
    } t_mouse_report;

    typedef enum logic {ROW_BYTE, ROW_MODE} t_row_kind;

    typedef struct {
        t_row_kind     kind;
        logic [7:0]    value;
        bit            typed;
        t_mouse_report want;
    } t_dir_row;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_BYTES  = 1850;
    // acceleration step per magnitude 0..15, entry 0 in the low nibble
    localparam logic [63:0] ACCEL_STEPS = {4'd15, 4'd12, 4'd10, 4'd8, 4'd6, 4'd5, 4'd4, 4'd3,
                                           4'd2, 4'd2, 4'd1, 4'd1, 4'd1, 4'd0, 4'd0, 4'd0};

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_cfg_wheel_mode;
    logic              i_data_valid;
    logic              o_data_ready;
    logic [7:0]        i_data_byte;
    logic              o_res_valid;
    logic              i_res_ready;
    logic [BTN_W-1:0]  o_buttons;
    logic signed [MOVE_W-1:0] o_move_x;
    logic signed [MOVE_W-1:0] o_move_y;
    logic [COL_W-1:0]  o_pos_x;
    logic [ROW_W-1:0]  o_pos_y;
    logic signed [SCR_W-1:0]  o_scroll;

    mouse_packet_position_tracker_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_wheel_mode (i_cfg_wheel_mode),
        .i_data_valid     (i_data_valid),
        .o_data_ready     (o_data_ready),
        .i_data_byte      (i_data_byte),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_buttons        (o_buttons),
        .o_move_x         (o_move_x),
        .o_move_y         (o_move_y),
        .o_pos_x          (o_pos_x),
        .o_pos_y          (o_pos_y),
        .o_scroll         (o_scroll)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // tracker state as seen by the bench
    bit         wheel_q = 1'b0;
    int         cnt_q   = 0;
    logic [7:0] pkt_q [3] = '{8'h00, 8'h00, 8'h00};
    int         col_q   = 40;
    int         row_q   = 12;

    t_mouse_report pending_reports[$];
    t_dir_row      dir_rows[$];

    int  fail_count    = 0;
    int  reports_seen  = 0;
    int  bytes_sent    = 0;
    int  mode_writes   = 0;
    int  stall_left    = 0;
    bit  hold_req      = 1'b0;
    bit  calm          = 1'b0;
    bit  hit_left, hit_right, hit_top, hit_bottom;

    function automatic int accelerate(input int d);
        int mag;
        mag = (d < 0) ? -d : d;
        if (mag > 15) mag = 15;
        return (d < 0) ? d - int'(ACCEL_STEPS[mag*4 +: 4]) : d + int'(ACCEL_STEPS[mag*4 +: 4]);
    endfunction

    function automatic int clip(input int v, input int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    // Feed one byte to the bench copy of the tracker; returns 1 when a packet completes.
    function automatic bit track_byte(input logic [7:0] b, output t_mouse_report rep);
        int last_idx, dx, dy, sc, nib;
        last_idx = wheel_q ? 3 : 2;
        rep = '0;
        if (cnt_q < last_idx) begin
            pkt_q[cnt_q] = b;
            cnt_q++;
            return 1'b0;
        end
        cnt_q = 0;
        dx = int'($signed(pkt_q[1]));
        if (wheel_q) begin
            nib = int'(b[3:0]);
            if (nib > 7) nib -= 16;
            dy = -int'($signed(pkt_q[2]));
            sc = -nib;
        end else begin
            // a mode drop mid-packet lands here too: this byte is the Y move
            dy = -int'($signed(b));
            sc = 0;
        end
        dx = accelerate(dx);
        dy = accelerate(dy);
        col_q = clip(col_q + dx, SCREEN_COLUMNS - 1);
        row_q = clip(row_q + dy, SCREEN_ROWS - 1);
        rep.buttons = pkt_q[0][BTN_W-1:0];
        rep.move_x  = dx[MOVE_W-1:0];
        rep.move_y  = dy[MOVE_W-1:0];
        rep.pos_x   = col_q[COL_W-1:0];
        rep.pos_y   = row_q[ROW_W-1:0];
        rep.scroll  = sc[SCR_W-1:0];
        return 1'b1;
    endfunction

    function automatic t_mouse_report mk_report(input int btn, input int mx, input int my,
                                                input int px, input int py, input int sc);
        t_mouse_report r;
        r.buttons = btn[BTN_W-1:0];
        r.move_x  = mx[MOVE_W-1:0];
        r.move_y  = my[MOVE_W-1:0];
        r.pos_x   = px[COL_W-1:0];
        r.pos_y   = py[ROW_W-1:0];
        r.scroll  = sc[SCR_W-1:0];
        return r;
    endfunction

    function automatic t_dir_row mk_row(input t_row_kind kind, input logic [7:0] value,
                                        input bit typed = 1'b0,
                                        input t_mouse_report want = '0);
        t_dir_row r;
        r.kind  = kind;
        r.value = value;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 35) return 8'(int'($urandom_range(18)) - 9);
        if (r < 55) begin
            case ($urandom_range(3))
                0:       return 8'h00;
                1:       return 8'h7F;
                2:       return 8'h80;
                default: return 8'hFF;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    // Called at a clock edge; leaves valid high so the next byte can follow without a gap.
    task automatic send_byte(input logic [7:0] b, input bit typed, input t_mouse_report want);
        int gap;
        t_mouse_report rep;
        gap = 0;
        if (!calm) while ($urandom_range(99) < 24) gap++;
        if (gap > 0) begin
            i_data_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_data_valid <= 1'b1;
        i_data_byte  <= b;
        do @(posedge i_clk); while (!o_data_ready);
        bytes_sent++;
        if (track_byte(b, rep)) pending_reports.push_back(typed ? want : rep);
    endtask

    task automatic wait_drained();
        i_data_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_wheel_mode(input bit v);
        wait_drained();
        i_cfg_valid      <= 1'b1;
        i_cfg_wheel_mode <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        wheel_q = v;
        mode_writes++;
    endtask

    function automatic void check_report(input t_mouse_report got);
        t_mouse_report want;
        if (pending_reports.size() == 0) begin
            $error("result transfer with nothing expected");
            fail_count++;
            return;
        end
        want = pending_reports.pop_front();
        reports_seen++;
        if (got.buttons !== want.buttons) begin
            $error("buttons: expected %0d, got %0d", want.buttons, got.buttons);
            fail_count++;
        end
        if (got.move_x !== want.move_x) begin
            $error("move_x: expected %0d, got %0d", want.move_x, got.move_x);
            fail_count++;
        end
        if (got.move_y !== want.move_y) begin
            $error("move_y: expected %0d, got %0d", want.move_y, got.move_y);
            fail_count++;
        end
        if (got.pos_x !== want.pos_x) begin
            $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
            fail_count++;
        end
        if (got.pos_y !== want.pos_y) begin
            $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
            fail_count++;
        end
        if (got.scroll !== want.scroll) begin
            $error("scroll: expected %0d, got %0d", want.scroll, got.scroll);
            fail_count++;
        end
        if (got.pos_x == 0) hit_left = 1'b1;
        if (got.pos_x == COL_MAX) hit_right = 1'b1;
        if (got.pos_y == 0) hit_top = 1'b1;
        if (got.pos_y == ROW_MAX) hit_bottom = 1'b1;
    endfunction

    // result side: check transfers, then pick ready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready)
            check_report({o_buttons, o_move_x, o_move_y, o_pos_x, o_pos_y, o_scroll});
        if (hold_req) begin
            stall_left = HOLD_CYCLES;
            hold_req   = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= calm || ($urandom_range(99) >= 24);
        end
    end

    initial begin
        int phase_len;
        int phase;
        bit mode;
        i_rst_n          <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_wheel_mode <= 1'b0;
        i_data_valid     <= 1'b0;
        i_data_byte      <= 8'h00;
        i_res_ready      <= 1'b0;
        {hit_left, hit_right, hit_top, hit_bottom} = '0;

        // three-byte packets from reset: full-scale moves pin the cursor to opposite corners
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h07));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h7F));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h80, 1'b1, mk_report(7, 142, 143, 79, 24, 0)));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h00));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h80));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h7F, 1'b1, mk_report(0, -143, -142, 0, 0, 0)));
        // header sign and overflow bits carry no weight
        dir_rows.push_back(mk_row(ROW_BYTE, 8'hF8));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h00));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h00, 1'b1, mk_report(0, 0, 0, 0, 0, 0)));
        // wheel packets, scroll at both ends, upper nibble ignored
        dir_rows.push_back(mk_row(ROW_MODE, 8'h01));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h02));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h01));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'hFF));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'hA8));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h05));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'hF1));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h0F));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h57));
        // drop to three-byte mode with three bytes held: the next byte closes the packet
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h03));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h04));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h05));
        dir_rows.push_back(mk_row(ROW_MODE, 8'h00));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'hFC));
        // raise to wheel mode with two bytes held: the packet grows to four
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h06));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h09));
        dir_rows.push_back(mk_row(ROW_MODE, 8'h01));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h0A));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h0B));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_MODE)
                set_wheel_mode(dir_rows[i].value[0]);
            else
                send_byte(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
        end

        phase = 0;
        while (bytes_sent < RANDOM_BYTES + dir_rows.size()) begin
            mode = (phase < 2) ? bit'(phase) : bit'($urandom_range(1));
            set_wheel_mode(mode);
            phase_len = $urandom_range(150, 220);
            calm = (phase == 5);
            if (phase == 3) begin
                // output blocked long enough to back up the packet queue and the byte input
                calm     = 1'b1;
                hold_req = 1'b1;
            end
            for (int k = 0; k < phase_len; k++) begin
                if (phase == 4 && k == phase_len / 2) wait_drained();
                send_byte(pick_byte(), 1'b0, '0);
            end
            calm = 1'b0;
            phase++;
        end

        wait_drained();
        $display("%0d bytes in %0d phases, %0d reports checked, %0d wheel mode writes",
                 bytes_sent, phase, reports_seen, mode_writes);
        $display("cursor edges reached: left %0b right %0b top %0b bottom %0b",
                 hit_left, hit_right, hit_top, hit_bottom);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mppt_pkg.sv
rtl/mppt_front.sv
rtl/mppt_fifo.sv
rtl/mppt_back.sv
rtl/mouse_packet_position_tracker_unit.sv
verif/tb_mouse_packet_position_tracker_unit.sv
